// File: src/sb2bcd_pkg.sv
// ----------------------------------------------------------------------------
// sb2bcd_pkg
// Shared types, constants and the power-of-ten table for the BCD converter.
// ----------------------------------------------------------------------------
package sb2bcd_pkg;

    localparam int VALUE_W        = 32;
    localparam int BCD_OUT_W      = 32;
    localparam int NIBBLE_W       = 4;
    localparam int DIGIT_COUNT_W  = 4;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_INDEX_W    = 1;
    localparam int MAX_DIGITS_DEF = 8;
    localparam int POW_W          = 36;

    localparam logic [DIGIT_COUNT_W-1:0] DIGIT_COUNT_RST = 4'd4;
    localparam logic                     SIGNED_MODE_RST = 1'b1;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
        logic finish;
    } sb2bcd_cmd_t;

    // 10^n for n = 0..10
    function automatic logic [POW_W-1:0] pow10(input logic [DIGIT_COUNT_W-1:0] n);
        logic [POW_W-1:0] p;
        case (n)
            4'd0:    p = 36'd1;
            4'd1:    p = 36'd10;
            4'd2:    p = 36'd100;
            4'd3:    p = 36'd1000;
            4'd4:    p = 36'd10000;
            4'd5:    p = 36'd100000;
            4'd6:    p = 36'd1000000;
            4'd7:    p = 36'd10000000;
            4'd8:    p = 36'd100000000;
            4'd9:    p = 36'd1000000000;
            4'd10:   p = 36'd10000000000;
            default: p = 36'd10000000000;
        endcase
        return p;
    endfunction

endpackage

// File: src/signed_binary_to_bcd.sv
// ----------------------------------------------------------------------------
// signed_binary_to_bcd
// Signed 32-bit integer to packed BCD, with configurable digit count and an
// optional sign nibble.
//
//   channel  dir   handshake                  payload
//   s_*      in    s_tvalid / s_tready        s_tdata: value (signed 32)
//   m_*      out   m_tvalid / m_tready        m_tdata: bcd_word, m_tuser: overflow
//   cfg_*    in    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// each item passes through a load step, 32 shift-add-3 steps through the
// digit register (one input bit per cycle), and a final step that writes the
// output register. the output register holds a finished beat while the next
// item is converted; a result waits in its last step only while that register
// is still full. reset gives 4 digits, signed mode and a last word of zero.
// configuration writes are always taken (cfg_ready tied high).
// ----------------------------------------------------------------------------
module signed_binary_to_bcd
#(
    parameter int MAX_DIGITS = sb2bcd_pkg::MAX_DIGITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input beats
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic signed [sb2bcd_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
    // result beats
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sb2bcd_pkg::BCD_OUT_W-1:0]      m_tdata,   // [31:0] bcd_word
    output logic [0:0]                            m_tuser,   // [0] overflow
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sb2bcd_pkg::CFG_INDEX_W-1:0]    cfg_index, // 0 digit_count, 1 signed_mode
    input  logic [sb2bcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sb2bcd_pkg::*;

    sb2bcd_cmd_t cmd;
    logic        overflow;

    // registers are written in any cycle
    assign cfg_ready = 1'b1;

    sb2bcd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sb2bcd_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bcd_word  (m_tdata),
        .overflow  (overflow)
    );

    assign m_tuser[0] = overflow;

endmodule

// File: src/sb2bcd_ctrl.sv
// ----------------------------------------------------------------------------
// sb2bcd_ctrl
// Sequencer: load, 32 shift steps, then hand the result to the output register.
// ----------------------------------------------------------------------------
module sb2bcd_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output sb2bcd_pkg::sb2bcd_cmd_t  cmd
);
    import sb2bcd_pkg::*;

    localparam int                CNT_W    = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(VALUE_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // output slot free or being emptied this cycle
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// File: src/sb2bcd_dp.sv
// ----------------------------------------------------------------------------
// sb2bcd_dp
// Datapath: magnitude, range check, shift-add-3 digit register, result hold.
// ----------------------------------------------------------------------------
module sb2bcd_dp
#(
    parameter int MAX_DIGITS = sb2bcd_pkg::MAX_DIGITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sb2bcd_pkg::sb2bcd_cmd_t              cmd,
    input  logic signed [sb2bcd_pkg::VALUE_W-1:0] value,
    input  logic                                 cfg_we,
    input  logic [sb2bcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sb2bcd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [sb2bcd_pkg::BCD_OUT_W-1:0]     bcd_word,
    output logic                                 overflow
);
    import sb2bcd_pkg::*;

    localparam int BW = MAX_DIGITS * NIBBLE_W;
    localparam int WW = (BW > BCD_OUT_W) ? BW : BCD_OUT_W;
    localparam logic [DIGIT_COUNT_W-1:0] MAX_D = DIGIT_COUNT_W'(MAX_DIGITS);

    logic [DIGIT_COUNT_W-1:0] digit_count_reg;
    logic                     signed_mode_reg;
    logic [BCD_OUT_W-1:0]     last_bcd_reg, last_bcd_next;

    logic [VALUE_W-1:0]       mag_reg, sh_reg;
    logic                     neg_reg;
    logic [BW-1:0]            bcd_reg, bcd_adj;
    logic [BCD_OUT_W-1:0]     out_bcd_reg, out_bcd_next;
    logic                     out_ovf_reg;

    logic [VALUE_W-1:0]       value_u, mag_in;
    logic [DIGIT_COUNT_W-1:0] d_act, pow_idx;
    logic                     ovf;
    logic [BW-1:0]            word;
    logic [WW-1:0]            word_ext;
    logic [BCD_OUT_W-1:0]     result;

    // two's complement magnitude, the most negative value maps to 2^31
    assign value_u = value;
    assign mag_in  = value_u[VALUE_W-1] ? (VALUE_W'(0) - value_u) : value_u;

    always_comb
    begin
        if (digit_count_reg == '0)
        begin
            d_act = DIGIT_COUNT_W'(1);
        end
        else if (digit_count_reg > MAX_D)
        begin
            d_act = MAX_D;
        end
        else
        begin
            d_act = digit_count_reg;
        end
    end

    assign pow_idx = signed_mode_reg ? (d_act - 1'b1) : d_act;
    assign ovf     = ({4'b0, mag_reg} >= pow10(pow_idx)) || (!signed_mode_reg && neg_reg);

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (bcd_reg[k*NIBBLE_W +: NIBBLE_W] >= 4'd5)
            begin
                bcd_adj[k*NIBBLE_W +: NIBBLE_W] = bcd_reg[k*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end
        end
    end

    // sign nibble 0001 on the top active digit
    always_comb
    begin
        word = bcd_reg;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (signed_mode_reg && neg_reg && (DIGIT_COUNT_W'(k) == d_act - 1'b1))
            begin
                word[k*NIBBLE_W] = 1'b1;
            end
        end
    end

    assign word_ext = WW'(word);
    assign result   = word_ext[BCD_OUT_W-1:0];

    assign out_bcd_next  = ovf ? last_bcd_reg : result;
    assign last_bcd_next = ovf ? last_bcd_reg : result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= DIGIT_COUNT_RST;
            signed_mode_reg <= SIGNED_MODE_RST;
            last_bcd_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIGIT_COUNT: digit_count_reg <= cfg_data[DIGIT_COUNT_W-1:0];
                    REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                    default:         digit_count_reg <= digit_count_reg;
                endcase
            end
            if (cmd.finish)
            begin
                last_bcd_reg <= last_bcd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag_in;
            sh_reg  <= mag_in;
            neg_reg <= value_u[VALUE_W-1];
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            sh_reg  <= {sh_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BW-2:0], sh_reg[VALUE_W-1]};
        end
        if (cmd.finish)
        begin
            out_bcd_reg <= out_bcd_next;
            out_ovf_reg <= ovf;
        end
    end

    assign bcd_word = out_bcd_reg;
    assign overflow = out_ovf_reg;

endmodule

// File: src/sb2bcd_checker.sv
// ----------------------------------------------------------------------------
// sb2bcd_checker
// Port-level checks for the BCD converter, bound to the top level.
// ----------------------------------------------------------------------------
module sb2bcd_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [sb2bcd_pkg::BCD_OUT_W-1:0]      m_tdata
);
    import sb2bcd_pkg::*;

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // one item at a time: input closes after a beat is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during a conversion");

    // a new result only appears out of a conversion, never while idle
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a conversion");

    // every nibble shown is a decimal digit
    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9) && (m_tdata[7:4] <= 4'd9)
            && (m_tdata[11:8] <= 4'd9) && (m_tdata[15:12] <= 4'd9)
            && (m_tdata[19:16] <= 4'd9) && (m_tdata[23:20] <= 4'd9)
            && (m_tdata[27:24] <= 4'd9) && (m_tdata[31:28] <= 4'd9))
        else $error("non-decimal nibble in result");

endmodule

bind signed_binary_to_bcd sb2bcd_checker u_sb2bcd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
